[src/urmh_pkg.sv]
package urmh_pkg;

  // Field widths of the measurement and result items.
  localparam int unsigned ECHO_W    = 16;
  localparam int unsigned CM_W      = 11;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 11;

  // Default ring length.
  localparam int unsigned WINDOW_LENGTH_DEF = 7;

  // Divide by 58 as a reciprocal multiply: q = (w * 72316) >> 22, exact for 16-bit w.
  localparam int unsigned DIV58_MUL_W = 17;
  localparam logic [DIV58_MUL_W-1:0] DIV58_MUL = 17'd72316;
  localparam int unsigned DIV58_SHIFT = 22;

  // Largest distance the widest echo can give.
  localparam logic [CM_W-1:0] MAX_CM = 11'd1129;

  // Quotient bits of the bar division (slot count stays below 32).
  localparam int unsigned BAR_Q_W = SLOT_W;

  // Register reset values.
  localparam logic [CM_W-1:0]   FAR_ON_RST   = 11'd110;
  localparam logic [CM_W-1:0]   NEAR_OFF_RST = 11'd90;
  localparam logic [CM_W-1:0]   FULL_SC_RST  = 11'd100;
  localparam logic [SLOT_W-1:0] SLOTS_RST    = 5'd21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAR_ON   = 4'd0,
    REG_NEAR_OFF = 4'd1,
    REG_FULL_SC  = 4'd2,
    REG_SLOTS    = 4'd3
  } cfg_reg_t;

  localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEAR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAR  = 2'd2;

  typedef struct packed {
    logic              echo_valid;
    logic [ECHO_W-1:0] echo_width_us;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] range_status;
    logic [CM_W-1:0]     median_cm;
    logic [SLOT_W-1:0]   bar_filled;
  } out_item_t;

endpackage

[src/ultrasonic_range_median_hysteresis.sv]
// Channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------------
// in_     | input     | in_valid / in_ready   | in_item_t  (echo_valid, echo_width_us)
// out_    | output    | out_valid / out_ready | out_item_t (range_status, median_cm,
//         |           |                       |             bar_filled)
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A good echo goes through the conversion, the median search, the multiply, the
// divide and the finish step; the next transfer can come as out_valid rises. The
// median search dominates: one shared comparator visits every pair of ring entries,
// L compares per candidate plus one check step, then one multiply step, five divide
// steps and one finish step. A failed echo goes from idle straight to the finish
// step, and so skips the median search and the division. in_ready is high only while
// the sequencer idles. The result sits in an output register, so a stalled
// out_ready holds only that register; the next measurement is taken and worked on
// up to the finish step, which waits until the register is free.
// Reset (synchronous, rst_n low) clears the ring, warm and far flags and loads the
// register defaults. cfg_ready is always high.
module ultrasonic_range_median_hysteresis
  import urmh_pkg::*;
#(
  parameter int unsigned WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned IW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_LENGTH + 1);
  localparam logic [CW-1:0] MED_POS = CW'(WINDOW_LENGTH / 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_LENGTH - 1);
  localparam int unsigned KW = $clog2(BAR_Q_W);
  localparam logic [KW-1:0] K_TOP = KW'(BAR_Q_W - 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CONV  = 8'b0000_0010,
    ST_MLOAD = 8'b0000_0100,
    ST_MCMP  = 8'b0000_1000,
    ST_MCHK  = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [CM_W-1:0]   far_on_r, near_off_r, full_sc_r;
  logic [SLOT_W-1:0] slots_r;

  // Ring of distances, kept as a shift line: newest at tap 0, oldest drops off the end.
  logic [CM_W-1:0] win_r [WINDOW_LENGTH];
  logic            warm_r;
  logic            far_r;

  logic [ECHO_W-1:0]  width_r;
  logic               fail_r;
  logic [CM_W-1:0]    cand_r;
  logic [CM_W-1:0]    med_r;
  logic               found_r;
  logic [CW-1:0]      less_r, le_r;
  logic [IW-1:0]      i_r, j_r;
  logic [ECHO_W-1:0]  rem_r;
  logic [BAR_Q_W-1:0] quo_r;
  logic [KW-1:0]      k_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // Shared compare/subtract unit: ring entry vs candidate, or remainder vs shifted divisor.
  logic [ECHO_W-1:0] cu_a, cu_b, cu_diff;
  logic              cu_lt, cu_eq;
  logic [ECHO_W-1:0] div_sh;

  assign div_sh = {{(ECHO_W-CM_W){1'b0}}, full_sc_r} << k_r;

  always_comb begin
    if (state_r == ST_DIV) begin
      cu_a = rem_r;
      cu_b = div_sh;
    end else begin
      cu_a = {{(ECHO_W-CM_W){1'b0}}, win_r[0]};
      cu_b = {{(ECHO_W-CM_W){1'b0}}, cand_r};
    end
  end

  assign cu_lt   = cu_a < cu_b;
  assign cu_eq   = cu_a == cu_b;
  assign cu_diff = cu_a - cu_b;

  // Width to centimetres.
  logic [ECHO_W+DIV58_MUL_W-1:0] conv_prod;
  logic [CM_W-1:0]               dcm;

  assign conv_prod = (ECHO_W+DIV58_MUL_W)'(width_r) * (ECHO_W+DIV58_MUL_W)'(DIV58_MUL);
  assign dcm       = conv_prod[DIV58_SHIFT +: CM_W];

  // Bar numerator and hysteresis update.
  logic [CM_W-1:0]   clamped;
  logic [ECHO_W-1:0] bar_prod;
  logic              far_nxt;

  assign clamped  = (med_r > full_sc_r) ? full_sc_r : med_r;
  assign bar_prod = ECHO_W'(clamped) * ECHO_W'(slots_r);

  always_comb begin
    priority if (!far_r && (med_r > far_on_r)) begin
      far_nxt = 1'b1;
    end else if (far_r && (med_r < near_off_r)) begin
      far_nxt = 1'b0;
    end else begin
      far_nxt = far_r;
    end
  end

  logic in_xfer, out_free;
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_data.echo_valid || (in_data.echo_width_us == '0)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV:  state_nxt = ST_MLOAD;
      ST_MLOAD: state_nxt = ST_MCMP;
      ST_MCMP: begin
        if (j_r == LAST_IDX) begin
          state_nxt = ST_MCHK;
        end
      end
      ST_MCHK: begin
        if (i_r == LAST_IDX) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_MCMP;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (k_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_on_r   <= FAR_ON_RST;
      near_off_r <= NEAR_OFF_RST;
      full_sc_r  <= FULL_SC_RST;
      slots_r    <= SLOTS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FAR_ON:   far_on_r   <= cfg_data;
        REG_NEAR_OFF: near_off_r <= cfg_data;
        REG_FULL_SC:  full_sc_r  <= cfg_data;
        REG_SLOTS:    slots_r    <= cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring, flags and the working registers of the median and bar steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LENGTH; k++) begin
        win_r[k] <= '0;
      end
      warm_r <= 1'b0;
      far_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            width_r <= in_data.echo_width_us;
            fail_r  <= !in_data.echo_valid || (in_data.echo_width_us == '0);
            if (!in_data.echo_valid || (in_data.echo_width_us == '0)) begin
              warm_r <= 1'b0;
            end
          end
        end
        ST_CONV: begin
          // Cold ring: fill every entry; warm ring: push out the oldest.
          if (!warm_r) begin
            for (int k = 0; k < WINDOW_LENGTH; k++) begin
              win_r[k] <= dcm;
            end
            warm_r <= 1'b1;
          end else begin
            win_r[0] <= dcm;
            for (int k = 1; k < WINDOW_LENGTH; k++) begin
              win_r[k] <= win_r[k-1];
            end
          end
        end
        ST_MLOAD: begin
          cand_r  <= win_r[0];
          less_r  <= '0;
          le_r    <= '0;
          i_r     <= '0;
          j_r     <= '0;
          found_r <= 1'b0;
        end
        ST_MCMP: begin
          // Count entries below and not above the candidate, rotate the ring.
          if (cu_lt) begin
            less_r <= less_r + 1'b1;
          end
          if (cu_lt || cu_eq) begin
            le_r <= le_r + 1'b1;
          end
          for (int k = 0; k < WINDOW_LENGTH - 1; k++) begin
            win_r[k] <= win_r[k+1];
          end
          win_r[WINDOW_LENGTH-1] <= win_r[0];
          j_r <= j_r + 1'b1;
        end
        ST_MCHK: begin
          // Candidate sits at the median rank when its equal run covers that rank.
          if (!found_r && (less_r <= MED_POS) && (le_r > MED_POS)) begin
            med_r   <= cand_r;
            found_r <= 1'b1;
          end
          // Advance to the next candidate; after L passes the ring is back in order.
          for (int k = 0; k < WINDOW_LENGTH - 1; k++) begin
            win_r[k] <= win_r[k+1];
          end
          win_r[WINDOW_LENGTH-1] <= win_r[0];
          cand_r <= win_r[1];
          less_r <= '0;
          le_r   <= '0;
          j_r    <= '0;
          i_r    <= i_r + 1'b1;
        end
        ST_MUL: begin
          far_r <= far_nxt;
          rem_r <= bar_prod;
          quo_r <= '0;
          k_r   <= K_TOP;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit a step.
          if (!cu_lt) begin
            rem_r <= cu_diff;
          end
          quo_r <= {quo_r[BAR_Q_W-2:0], !cu_lt};
          k_r   <= k_r - 1'b1;
        end
        ST_FIN: ;
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      if (fail_r) begin
        out_data_r.range_status <= STATUS_FAIL;
        out_data_r.median_cm    <= '0;
        out_data_r.bar_filled   <= '0;
      end else begin
        out_data_r.range_status <= far_r ? STATUS_FAR : STATUS_NEAR;
        out_data_r.median_cm    <= med_r;
        out_data_r.bar_filled   <= (full_sc_r == '0) ? '0 : quo_r;
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/urmh_checker.sv]
module urmh_checker
  import urmh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Failure reports zero distance and an empty bar.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.range_status == STATUS_FAIL)
      |-> (out_data.median_cm == '0) && (out_data.bar_filled == '0))
    else $error("failure result carries nonzero fields");

  // Status code stays in range and the median stays within reach of the echo.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.range_status == STATUS_FAIL) ||
                   (out_data.range_status == STATUS_NEAR) ||
                   (out_data.range_status == STATUS_FAR)) &&
                  (out_data.median_cm <= MAX_CM))
    else $error("result out of range");

  // Drop any result on reset.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ultrasonic_range_median_hysteresis urmh_checker u_urmh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

[bench/tb.sv]
module tb;
  import urmh_pkg::*;

  localparam int RING_LEN = WINDOW_LENGTH_DEF;
  localparam int US_PER_CM = 58;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASE_ITEMS = 175;
  // Index past the last register; writes there must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  ultrasonic_range_median_hysteresis uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Echo measurements waiting to be sent, and the range reports they must produce.
  in_item_t echo_q[$];
  out_item_t report_q[$];
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  // Set to suppress all random idling on both channels.
  bit steady = 1'b0;

  // Shadow of the block: distance ring, write slot, warm flag, far flag, registers.
  logic [CM_W-1:0] ring_cm[RING_LEN];
  int ring_pos;
  bit ring_warm;
  bit is_far;
  logic [CM_W-1:0] thr_far = FAR_ON_RST;
  logic [CM_W-1:0] thr_near = NEAR_OFF_RST;
  logic [CM_W-1:0] bar_scale = FULL_SC_RST;
  logic [SLOT_W-1:0] bar_slots = SLOTS_RST;

  initial begin
    for (int i = 0; i < RING_LEN; i++) ring_cm[i] = '0;
    ring_pos = 0;
    ring_warm = 1'b0;
    is_far = 1'b0;
  end

  // Advance the shadow by one measurement and return the report it yields.
  function automatic out_item_t range_next(in_item_t m);
    logic [CM_W-1:0] srt[RING_LEN];
    logic [CM_W-1:0] dcm, med, tmp;
    int clamped;
    out_item_t r;
    r = '0;
    // A missing or zero-width echo only drops the warm flag; ring and far flag hold.
    if (!m.echo_valid || m.echo_width_us == '0) begin
      ring_warm = 1'b0;
      r.range_status = STATUS_FAIL;
      return r;
    end
    dcm = CM_W'(int'(m.echo_width_us) / US_PER_CM);
    ring_cm[ring_pos] = dcm;
    ring_pos = (ring_pos == RING_LEN - 1) ? 0 : ring_pos + 1;
    // First good echo after reset or a failure seeds the whole ring.
    if (!ring_warm) begin
      for (int i = 0; i < RING_LEN; i++) ring_cm[i] = dcm;
      ring_warm = 1'b1;
    end
    for (int i = 0; i < RING_LEN; i++) srt[i] = ring_cm[i];
    for (int i = 1; i < RING_LEN; i++)
      for (int j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
        tmp = srt[j];
        srt[j] = srt[j-1];
        srt[j-1] = tmp;
      end
    med = srt[RING_LEN / 2];
    // Set is checked only while near and clear only while far; at most one flip per measurement.
    if (!is_far && med > thr_far) is_far = 1'b1;
    else if (is_far && med < thr_near) is_far = 1'b0;
    r.range_status = is_far ? STATUS_FAR : STATUS_NEAR;
    r.median_cm = med;
    if (bar_scale == '0) begin
      r.bar_filled = '0;
    end else begin
      clamped = (med > bar_scale) ? int'(bar_scale) : int'(med);
      r.bar_filled = SLOT_W'((clamped * int'(bar_slots)) / int'(bar_scale));
    end
    return r;
  endfunction

  // Input driver: launch the next echo once the current one has transferred.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken_cnt == sent_cnt) begin
      if (echo_q.size() > 0 && (steady || $urandom_range(0, 99) >= 30)) begin
        in_data <= echo_q.pop_front();
        in_valid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // Predict on every input transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      report_q.push_back(range_next(in_data));
      taken_cnt <= taken_cnt + 1;
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $display("%0t: expected no report, got status %0d median %0d bar %0d", $time,
                 out_data.range_status, out_data.median_cm, out_data.bar_filled);
        errors++;
      end else begin
        want = report_q.pop_front();
        if (out_data !== want) begin
          $display("%0t: expected status %0d median %0d bar %0d, got %0d %0d %0d",
                   $time, want.range_status, want.median_cm, want.bar_filled,
                   out_data.range_status, out_data.median_cm, out_data.bar_filled);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_echo(bit v, int w, int n);
    in_item_t m;
    m.echo_valid = v;
    m.echo_width_us = ECHO_W'(w);
    repeat (n) echo_q.push_back(m);
  endtask

  // Hold until every queued echo has transferred and every report has come back.
  task automatic drain();
    do @(negedge clk);
    while (echo_q.size() != 0 || taken_cnt != sent_cnt || report_q.size() != 0);
  endtask

  // Register write; update the shadow registers on the transfer.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx)
      REG_FAR_ON:   thr_far = val;
      REG_NEAR_OFF: thr_near = val;
      REG_FULL_SC:  bar_scale = val;
      REG_SLOTS:    bar_slots = val[SLOT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random echoes: mostly distances clustered around the live thresholds and
  // full scale so the flag and bar edges get hit, with failures and wild widths.
  task automatic fill_random(int n);
    int r, cm, w;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        add_echo(1'b0, $urandom_range(0, 65535), 1);
      end else if (r < 10) begin
        add_echo(1'($urandom_range(0, 1)), 0, 1);
      end else if (r < 30) begin
        add_echo(1'b1, $urandom_range(1, 65535), 1);
      end else begin
        case ($urandom_range(0, 3))
          0: cm = int'(thr_far);
          1: cm = int'(thr_near);
          2: cm = int'(bar_scale);
          default: cm = $urandom_range(0, 40);
        endcase
        cm = cm + $urandom_range(0, 40) - 20;
        if (cm < 0) cm = 0;
        if (cm > int'(MAX_CM)) cm = int'(MAX_CM);
        w = cm * US_PER_CM + $urandom_range(0, US_PER_CM - 1);
        if (w > 65535) w = 65535;
        if (w == 0) w = 1;
        add_echo(1'b1, w, 1);
      end
    end
  endtask

  initial begin
    int far_v, near_v;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed pass at reset register values (far above 110, near below 90).
    add_echo(1'b0, 16'hFFFF, 1);     // no echo, widest width
    add_echo(1'b1, 0, 1);            // zero width counts as failure
    add_echo(1'b0, 0, 1);
    add_echo(1'b1, 57, 1);           // rounds down to 0 cm, seeds the ring
    add_echo(1'b1, 58, 1);           // 1 cm
    add_echo(1'b1, 65535, 1);        // largest distance, median stays low
    add_echo(1'b0, 5800, 1);         // failure clears warm
    add_echo(1'b1, 65535, 1);        // reseed at max: far sets
    add_echo(1'b1, 100 * US_PER_CM, 4); // median 100 inside the band: far holds
    add_echo(1'b1, 80 * US_PER_CM, 4);  // median drops below 90: far clears
    add_echo(1'b1, 95 * US_PER_CM, 4);  // inside the band: near holds
    add_echo(1'b1, 0, 1);
    add_echo(1'b1, 120 * US_PER_CM + 57, 1);
    drain();

    for (int p = 0; p < 8; p++) begin
      steady = (p == 4);
      case (p)
        0: begin
          cfg_write(REG_FAR_ON, 11'd0);
          cfg_write(REG_NEAR_OFF, 11'd0);
          cfg_write(REG_FULL_SC, 11'd1);
          cfg_write(REG_SLOTS, 11'd31);
        end
        1: begin
          cfg_write(REG_FAR_ON, 11'h7FF);
          cfg_write(REG_NEAR_OFF, 11'h7FF);
          cfg_write(REG_FULL_SC, 11'h7FF);
          cfg_write(REG_SLOTS, 11'd1);
        end
        2: begin
          // Inverted band and zero full scale / zero slots.
          cfg_write(REG_FAR_ON, 11'd300);
          cfg_write(REG_NEAR_OFF, 11'd600);
          cfg_write(REG_FULL_SC, 11'd0);
          cfg_write(REG_SLOTS, 11'd0);
        end
        3: begin
          cfg_write(REG_FAR_ON, 11'd1129);
          cfg_write(REG_NEAR_OFF, 11'd1);
          cfg_write(REG_FULL_SC, 11'd1129);
          cfg_write(REG_SLOTS, 11'h7E5);  // upper bits drop, 5 slots remain
          cfg_write(REG_UNUSED, CFG_DAT_W'($urandom_range(0, 2047)));
        end
        default: begin
          far_v = $urandom_range(0, 1129);
          near_v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1129)
                                                : $urandom_range(0, far_v);
          cfg_write(REG_FAR_ON, CFG_DAT_W'(far_v));
          cfg_write(REG_NEAR_OFF, CFG_DAT_W'(near_v));
          cfg_write(REG_FULL_SC, CFG_DAT_W'($urandom_range(1, 1129)));
          cfg_write(REG_SLOTS, CFG_DAT_W'($urandom_range(0, 2047)));
          if ($urandom_range(0, 1)) begin
            cfg_write(REG_UNUSED + CFG_IDX_W'(p - 4), CFG_DAT_W'($urandom_range(0, 2047)));
          end
        end
      endcase
      fill_random(PHASE_ITEMS);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (report_q.size() != 0) begin
      $display("%0t: %0d reports never arrived", $time, report_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
